// ===== hw/rtl/rsgt_pkg.sv =====
//------------------------------------------------------------------------------
// rsgt_pkg: shared types and constants of the receive sequence gap tracker.
// Holds the word formats of both channels, the descriptor handed from the
// front end to the back end, result kinds, tone codes and register indexes.
//------------------------------------------------------------------------------
package rsgt_pkg;

    // Default values of the top level parameters.
    localparam int MAX_MARKERS_DEF = 15;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Width of a marker count; the conceal limit register is four bits wide.
    localparam int MARK_W = 4;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Repeat suppression window in milliseconds.
    localparam logic [31:0] REPEAT_WINDOW_MS = 32'd1000;

    // Sequence difference that marks a duplicate (same number again).
    localparam logic [7:0] SEQ_DUP = 8'hFF;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_MAGIC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MAGIC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONCEAL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CALL_STATE_CODE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_CODE       = 3'd7;

    // Register reset values.
    localparam logic [MARK_W-1:0] MAX_CONCEAL_RST = 4'd2;
    localparam logic [7:0]        BEEP_CODE_RST   = 8'd1;

    // Kind of one result word.
    typedef enum logic [2:0] {
        KIND_LOST      = 3'd0,
        KIND_DELIVERED = 3'd1,
        KIND_DUPLICATE = 3'd2,
        KIND_QDROP     = 3'd3,
        KIND_CONTROL   = 3'd4,
        KIND_REPEAT    = 3'd5,
        KIND_IGNORED   = 3'd6,
        KIND_MODE      = 3'd7
    } t_kind;

    // Tone request codes.
    typedef enum logic [1:0] {
        TONE_NONE      = 2'd0,
        TONE_CONNECTED = 2'd1,
        TONE_IDLE      = 2'd2,
        TONE_YOUR_TURN = 2'd3
    } t_tone;

    // Input word: one packet header or a mode change.
    typedef struct packed {
        logic        action;
        logic [7:0]  packet_length;
        logic [7:0]  lead_byte;
        logic [15:0] source_id;
        logic [7:0]  seq_or_type;
        logic [7:0]  control_arg;
        logic [31:0] time_ms;
        logic        queue_full;
    } t_in_word;

    // Result word.
    typedef struct packed {
        t_kind       kind;
        logic        last;
        t_tone       tone_request;
        logic        in_call;
        logic [31:0] received_count;
        logic [31:0] lost_count;
        logic [31:0] dropped_count;
    } t_out_word;

    // Classified item: final result plus the number of lost markers before it.
    typedef struct packed {
        t_kind              kind;
        t_tone              tone;
        logic [MARK_W-1:0]  markers;
        logic               in_call;
        logic [31:0]        received_count;
        logic [31:0]        lost_count;
        logic [31:0]        dropped_count;
    } t_desc;

endpackage

// ===== hw/rtl/rsgt_queue.sv =====
//------------------------------------------------------------------------------
// rsgt_queue: short descriptor queue between front end and back end.
// Register based, first in first out, head always visible on the read side.
//------------------------------------------------------------------------------
module rsgt_queue #(
    parameter int DEPTH = rsgt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  rsgt_pkg::t_desc i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output rsgt_pkg::t_desc o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    rsgt_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Entry storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/rsgt_front.sv =====
//------------------------------------------------------------------------------
// rsgt_front: configuration registers, item classification and state update.
// Each accepted word is classified, the tracker state and the counters are
// updated, and one descriptor is written to the queue.
//------------------------------------------------------------------------------
module rsgt_front #(
    parameter int MAX_MARKERS = rsgt_pkg::MAX_MARKERS_DEF,
    parameter int COUNT_WIDTH = rsgt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  rsgt_pkg::t_in_word              i_word,
    output logic                            o_full,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsgt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsgt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_q_wr,
    output rsgt_pkg::t_desc                 o_q_wdata,
    input  logic                            i_q_full
);

    localparam int CW = COUNT_WIDTH;
    localparam int MW = rsgt_pkg::MARK_W;
    localparam logic [7:0] MAX_MARKERS_B = 8'(MAX_MARKERS);

    // Configuration registers.
    logic [15:0]   r_own_node_id;
    logic [7:0]    r_audio_magic;
    logic [7:0]    r_control_magic;
    logic [7:0]    r_audio_length;
    logic [7:0]    r_control_length;
    logic [MW-1:0] r_max_conceal;
    logic [7:0]    r_call_state_code;
    logic [7:0]    r_beep_code;

    // Tracker state and its next values.
    logic          r_have_seq,  n_have_seq;
    logic [7:0]    r_prev_seq,  n_prev_seq;
    logic [15:0]   r_talker,    n_talker;
    logic [CW-1:0] r_received,  n_received;
    logic [CW-1:0] r_lost,      n_lost;
    logic [CW-1:0] r_dropped,   n_dropped;
    logic          r_call,      n_call;
    logic [7:0]    r_prior_type, n_prior_type;
    logic [7:0]    r_prior_arg,  n_prior_arg;
    logic [31:0]   r_prior_time, n_prior_time;

    logic          accept;
    logic          is_control;
    logic          is_audio;
    logic          is_repeat;
    logic [31:0]   time_diff;
    logic          same_talker;
    logic [7:0]    gap;
    logic          is_dup;
    logic          in_limit;
    rsgt_pkg::t_kind kind;
    rsgt_pkg::t_tone tone;
    logic [MW-1:0] markers;
    logic [63:0]   recv_ext;
    logic [63:0]   lost_ext;
    logic [63:0]   drop_ext;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_q_full;
    assign accept      = i_push && !i_q_full;

    // Format and repeat checks.
    assign is_control  = (i_word.packet_length == r_control_length) &&
                         (i_word.lead_byte == r_control_magic);
    assign is_audio    = (i_word.packet_length == r_audio_length) &&
                         (i_word.lead_byte == r_audio_magic);
    assign time_diff   = i_word.time_ms - r_prior_time;
    assign is_repeat   = (i_word.seq_or_type == r_prior_type) &&
                         (i_word.control_arg == r_prior_arg) &&
                         (time_diff < rsgt_pkg::REPEAT_WINDOW_MS);

    // Sequence tracking: a different talker forgets the sequence.
    assign same_talker = r_have_seq && (i_word.source_id == r_talker);
    assign gap         = i_word.seq_or_type - r_prev_seq - 8'd1;
    assign is_dup      = same_talker && (gap == rsgt_pkg::SEQ_DUP);
    assign in_limit    = (gap != 8'd0) && (gap <= {4'b0, r_max_conceal}) &&
                         (gap <= MAX_MARKERS_B);

    // Next state and descriptor content.
    always_comb begin
        n_have_seq   = r_have_seq;
        n_prev_seq   = r_prev_seq;
        n_talker     = r_talker;
        n_received   = r_received;
        n_lost       = r_lost;
        n_dropped    = r_dropped;
        n_call       = r_call;
        n_prior_type = r_prior_type;
        n_prior_arg  = r_prior_arg;
        n_prior_time = r_prior_time;
        kind         = rsgt_pkg::KIND_IGNORED;
        tone         = rsgt_pkg::TONE_NONE;
        markers      = '0;

        if (i_word.action) begin
            n_have_seq = 1'b0;
            kind       = rsgt_pkg::KIND_MODE;
        end else if (i_word.source_id == r_own_node_id) begin
            kind = rsgt_pkg::KIND_IGNORED;
        end else if (is_control) begin
            if (is_repeat) begin
                kind = rsgt_pkg::KIND_REPEAT;
            end else begin
                kind         = rsgt_pkg::KIND_CONTROL;
                n_prior_type = i_word.seq_or_type;
                n_prior_arg  = i_word.control_arg;
                n_prior_time = i_word.time_ms;
                if (i_word.seq_or_type == r_call_state_code) begin
                    n_call = (i_word.control_arg != 8'd0);
                    tone   = n_call ? rsgt_pkg::TONE_CONNECTED : rsgt_pkg::TONE_IDLE;
                end else if (i_word.seq_or_type == r_beep_code) begin
                    tone = rsgt_pkg::TONE_YOUR_TURN;
                end
            end
        end else if (!is_audio) begin
            kind = rsgt_pkg::KIND_IGNORED;
        end else if (is_dup) begin
            n_dropped = r_dropped + CW'(1);
            kind      = rsgt_pkg::KIND_DUPLICATE;
        end else begin
            n_have_seq = 1'b1;
            n_prev_seq = i_word.seq_or_type;
            n_talker   = i_word.source_id;
            n_received = r_received + CW'(1);
            if (same_talker) begin
                n_lost = r_lost + CW'(gap);
                if (in_limit) begin
                    markers = gap[MW-1:0];
                end
            end
            if (i_word.queue_full) begin
                n_dropped = r_dropped + CW'(1);
                kind      = rsgt_pkg::KIND_QDROP;
            end else begin
                kind = rsgt_pkg::KIND_DELIVERED;
            end
        end
    end

    // Counters as seen on the result ports.
    assign recv_ext = 64'(n_received);
    assign lost_ext = 64'(n_lost);
    assign drop_ext = 64'(n_dropped);

    always_comb begin
        o_q_wdata.kind           = kind;
        o_q_wdata.tone           = tone;
        o_q_wdata.markers        = markers;
        o_q_wdata.in_call        = n_call;
        o_q_wdata.received_count = recv_ext[31:0];
        o_q_wdata.lost_count     = lost_ext[31:0];
        o_q_wdata.dropped_count  = drop_ext[31:0];
    end

    assign o_q_wr = accept;

    // Configuration and tracker state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node_id     <= '0;
            r_audio_magic     <= '0;
            r_control_magic   <= '0;
            r_audio_length    <= '0;
            r_control_length  <= '0;
            r_max_conceal     <= rsgt_pkg::MAX_CONCEAL_RST;
            r_call_state_code <= '0;
            r_beep_code       <= rsgt_pkg::BEEP_CODE_RST;
            r_have_seq        <= 1'b0;
            r_prev_seq        <= '0;
            r_talker          <= '0;
            r_received        <= '0;
            r_lost            <= '0;
            r_dropped         <= '0;
            r_call            <= 1'b0;
            r_prior_type      <= '0;
            r_prior_arg       <= '0;
            r_prior_time      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rsgt_pkg::REG_OWN_NODE_ID:     r_own_node_id     <= i_cfg_data;
                    rsgt_pkg::REG_AUDIO_MAGIC:     r_audio_magic     <= i_cfg_data[7:0];
                    rsgt_pkg::REG_CONTROL_MAGIC:   r_control_magic   <= i_cfg_data[7:0];
                    rsgt_pkg::REG_AUDIO_LENGTH:    r_audio_length    <= i_cfg_data[7:0];
                    rsgt_pkg::REG_CONTROL_LENGTH:  r_control_length  <= i_cfg_data[7:0];
                    rsgt_pkg::REG_MAX_CONCEAL:     r_max_conceal     <= i_cfg_data[MW-1:0];
                    rsgt_pkg::REG_CALL_STATE_CODE: r_call_state_code <= i_cfg_data[7:0];
                    rsgt_pkg::REG_BEEP_CODE:       r_beep_code       <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_have_seq   <= n_have_seq;
                r_prev_seq   <= n_prev_seq;
                r_talker     <= n_talker;
                r_received   <= n_received;
                r_lost       <= n_lost;
                r_dropped    <= n_dropped;
                r_call       <= n_call;
                r_prior_type <= n_prior_type;
                r_prior_arg  <= n_prior_arg;
                r_prior_time <= n_prior_time;
            end
        end
    end

endmodule

// ===== hw/rtl/rsgt_back.sv =====
//------------------------------------------------------------------------------
// rsgt_back: expands one descriptor into its result words.
// Emits the lost markers first, then the final word of the item, one word
// per cycle while the output register, which the consumer pops, has room.
//------------------------------------------------------------------------------
module rsgt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  rsgt_pkg::t_desc    i_q_rdata,
    output logic               o_q_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output rsgt_pkg::t_out_word o_word
);

    localparam int MW = rsgt_pkg::MARK_W;

    rsgt_pkg::t_out_word r_out;
    logic                r_out_valid;
    logic [MW-1:0]       r_sent;
    logic                slot_free;
    logic                emit;
    logic                emit_marker;
    rsgt_pkg::t_out_word next_word;

    assign o_empty     = !r_out_valid;
    assign o_word      = r_out;
    assign slot_free   = !r_out_valid || i_pop;
    assign emit        = i_q_valid && slot_free;
    assign emit_marker = (r_sent != i_q_rdata.markers);
    assign o_q_rd      = emit && !emit_marker;

    // Build the next word from the queue head.
    always_comb begin
        next_word.in_call        = i_q_rdata.in_call;
        next_word.received_count = i_q_rdata.received_count;
        next_word.lost_count     = i_q_rdata.lost_count;
        next_word.dropped_count  = i_q_rdata.dropped_count;
        if (emit_marker) begin
            next_word.kind         = rsgt_pkg::KIND_LOST;
            next_word.last         = 1'b0;
            next_word.tone_request = rsgt_pkg::TONE_NONE;
        end else begin
            next_word.kind         = i_q_rdata.kind;
            next_word.last         = 1'b1;
            next_word.tone_request = i_q_rdata.tone;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= next_word;
        end
    end

    // Output valid flag and marker counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sent      <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                r_sent <= emit_marker ? r_sent + MW'(1) : '0;
            end
        end
    end

endmodule

// ===== hw/rtl/rx_sequence_gap_tracker_core.sv =====
//------------------------------------------------------------------------------
// rx_sequence_gap_tracker_core: receive header tracker with gap concealment.
// The front end takes one word per cycle while the descriptor queue has room;
// every word produces one result word plus up to fifteen lost markers ahead of
// an audio item. The back end emits one result word per cycle, while the
// output register is empty or being popped, so an item yields 1 to 1+markers
// words (at most 16); that back-end word rate sets the sustained throughput,
// and the queue of QUEUE_DEPTH descriptors absorbs bursts in between.
//------------------------------------------------------------------------------
module rx_sequence_gap_tracker_core #(
    parameter int MAX_MARKERS = rsgt_pkg::MAX_MARKERS_DEF,
    parameter int COUNT_WIDTH = rsgt_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rsgt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  rsgt_pkg::t_in_word              i_word,
    output logic                            o_full,
    output logic                            o_empty,
    input  logic                            i_pop,
    output rsgt_pkg::t_out_word             o_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsgt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsgt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic            q_wr;
    rsgt_pkg::t_desc q_wdata;
    logic            q_full;
    logic            q_rd;
    logic            q_valid;
    rsgt_pkg::t_desc q_rdata;

    // Classification and state update.
    rsgt_front #(
        .MAX_MARKERS (MAX_MARKERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_word      (i_word),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_q_wr      (q_wr),
        .o_q_wdata   (q_wdata),
        .i_q_full    (q_full)
    );

    // Descriptor queue between the two halves.
    rsgt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    // Result word generation.
    rsgt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rdata (q_rdata),
        .o_q_rd    (q_rd),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_word    (o_word)
    );

endmodule
